// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the register file RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/aurf_pkg.sv =====
// ----------------------------------------------------------------------------
// aurf_pkg
// Types and constants of the sound unit register file.
// ----------------------------------------------------------------------------
package aurf_pkg;

    localparam int WAVE_BYTES_DEFAULT = 16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } request_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       channel_one_active;
    } response_t;

    // transfer kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // register map
    localparam logic [15:0] ADDR_SWEEP     = 16'hFF10;
    localparam logic [15:0] ADDR_CH1_DUTY  = 16'hFF11;
    localparam logic [15:0] ADDR_CH1_ENV   = 16'hFF12;
    localparam logic [15:0] ADDR_CH1_PLOW  = 16'hFF13;
    localparam logic [15:0] ADDR_CH1_CTRL  = 16'hFF14;
    localparam logic [15:0] ADDR_CH2_DUTY  = 16'hFF16;
    localparam logic [15:0] ADDR_CH2_ENV   = 16'hFF17;
    localparam logic [15:0] ADDR_CH2_PLOW  = 16'hFF18;
    localparam logic [15:0] ADDR_CH2_CTRL  = 16'hFF19;
    localparam logic [15:0] ADDR_CH3_EN    = 16'hFF1A;
    localparam logic [15:0] ADDR_CH3_LEN   = 16'hFF1B;
    localparam logic [15:0] ADDR_CH3_LEVEL = 16'hFF1C;
    localparam logic [15:0] ADDR_CH3_PLOW  = 16'hFF1D;
    localparam logic [15:0] ADDR_CH3_CTRL  = 16'hFF1E;
    localparam logic [15:0] ADDR_CH4_LEN   = 16'hFF20;
    localparam logic [15:0] ADDR_CH4_ENV   = 16'hFF21;
    localparam logic [15:0] ADDR_CH4_FREQ  = 16'hFF22;
    localparam logic [15:0] ADDR_CH4_CTRL  = 16'hFF23;
    localparam logic [15:0] ADDR_VOLUME    = 16'hFF24;
    localparam logic [15:0] ADDR_PANNING   = 16'hFF25;
    localparam logic [15:0] ADDR_POWER     = 16'hFF26;
    localparam logic [15:0] WAVE_BASE      = 16'hFF30;

    // read masks
    localparam logic [7:0] MASK_SWEEP = 8'h80;
    localparam logic [7:0] MASK_DUTY  = 8'h3F;
    localparam logic [7:0] MASK_CTRL  = 8'hBF;
    localparam logic [7:0] MASK_LEVEL = 8'h9F;
    localparam logic [7:0] MASK_CH3EN = 8'h7F;
    localparam logic [7:0] MASK_POWER = 8'h70;
    localparam logic [7:0] POWER_KEEP = 8'hF0;
    localparam logic [7:0] READ_NONE  = 8'hFF;

    // reset values
    localparam logic [7:0] VOLUME_RESET  = 8'h77;
    localparam logic [7:0] PANNING_RESET = 8'hF3;
    localparam logic [7:0] POWER_RESET   = 8'hF1;

    localparam logic [5:0] LEN_LAST   = 6'd63;
    localparam logic [3:0] PHASE_WRAP = 4'd8;

endpackage

// ===== sv/audio_unit_register_file.sv =====
// ----------------------------------------------------------------------------
// audio_unit_register_file
// Register file of a four-channel sound unit: bus reads, bus writes, ticks.
// ----------------------------------------------------------------------------
// One transfer is taken in every cycle: busy is held low, so start alone
// accepts a transfer. The transfer is registered, then decoded and applied
// to the register state in the following cycle. Its result is loaded onto
// response and is shown with done high for exactly one cycle. The receiver
// cannot stall; every result must be taken in the cycle it appears.
// Throughput is one transfer per cycle.
module audio_unit_register_file #(
    parameter int WAVE_BYTES = aurf_pkg::WAVE_BYTES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  aurf_pkg::request_t  request,
    output logic                done,
    output aurf_pkg::response_t response
);

`include "assert_macros.svh"

    logic                req_valid_reg;
    aurf_pkg::request_t  req_reg;
    logic                done_reg;
    aurf_pkg::response_t response_reg;
    aurf_pkg::response_t rsp_next;

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign response = response_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start && !busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        if (req_valid_reg)
        begin
            response_reg <= rsp_next;
        end
    end

    aurf_core #(
        .WAVE_BYTES (WAVE_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (req_valid_reg),
        .req   (req_reg),
        .rsp   (rsp_next)
    );

    // every accepted transfer yields exactly one result
    `ASSERT_NEXT(a_done_after_item, clk, rst_n, req_valid_reg, done)
    `ASSERT_SAME(a_done_has_item, clk, rst_n, done, $past(req_valid_reg))
    // only reads return anything other than all ones
    `ASSERT_SAME(a_data_only_on_read, clk, rst_n,
                 done && (response.read_data != aurf_pkg::READ_NONE),
                 $past(req_reg.kind) == aurf_pkg::KIND_READ)

endmodule

// ===== sv/aurf_core.sv =====
// ----------------------------------------------------------------------------
// aurf_core
// Register state, wave store and single-pass update for one transfer.
// ----------------------------------------------------------------------------
module aurf_core #(
    parameter int WAVE_BYTES = aurf_pkg::WAVE_BYTES_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  aurf_pkg::request_t  req,
    output aurf_pkg::response_t rsp
);

    localparam int IDX_W = (WAVE_BYTES > 1) ? $clog2(WAVE_BYTES) : 1;

    typedef struct packed {
        logic [7:0] sweep_setting;
        logic [7:0] ch1_duty_length;
        logic [7:0] ch1_envelope;
        logic [7:0] ch1_period_low;
        logic [7:0] ch1_control;
        logic [7:0] ch2_duty_length;
        logic [7:0] ch2_envelope;
        logic [7:0] ch2_period_low;
        logic [7:0] ch2_control;
        logic [7:0] ch3_enable;
        logic [7:0] ch3_length;
        logic [7:0] ch3_level;
        logic [7:0] ch3_period_low;
        logic [7:0] ch3_control;
        logic [7:0] ch4_length;
        logic [7:0] ch4_envelope;
        logic [7:0] ch4_frequency;
        logic [7:0] ch4_control;
        logic [7:0] master_volume;
        logic [7:0] panning;
        logic [7:0] power_control;
        logic [3:0] tick_phase;
    } regs_t;

    localparam regs_t REGS_RESET = '{
        master_volume: aurf_pkg::VOLUME_RESET,
        panning:       aurf_pkg::PANNING_RESET,
        power_control: aurf_pkg::POWER_RESET,
        default:       '0
    };

    regs_t            regs_reg;
    regs_t            regs_next;
    logic [7:0]       wave_reg [WAVE_BYTES];
    logic             wave_we;
    logic [15:0]      wave_offset;
    logic             wave_hit;
    logic [IDX_W-1:0] wave_idx;
    logic             powered;
    logic [7:0]       read_value;
    logic [7:0]       rd;
    logic [3:0]       phase;
    logic [5:0]       len;
    logic [7:0]       d;

    assign wave_offset = req.address - aurf_pkg::WAVE_BASE;
    assign wave_hit    = (req.address >= aurf_pkg::WAVE_BASE) &&
                         (wave_offset < 16'(WAVE_BYTES));
    assign wave_idx    = wave_offset[IDX_W-1:0];
    assign powered     = regs_reg.power_control[7];
    assign d           = req.write_data;

    // read mux
    always_comb
    begin
        unique case (req.address)
            aurf_pkg::ADDR_SWEEP:     read_value = regs_reg.sweep_setting | aurf_pkg::MASK_SWEEP;
            aurf_pkg::ADDR_CH1_DUTY:  read_value = regs_reg.ch1_duty_length | aurf_pkg::MASK_DUTY;
            aurf_pkg::ADDR_CH1_ENV:   read_value = regs_reg.ch1_envelope;
            aurf_pkg::ADDR_CH1_CTRL:  read_value = regs_reg.ch1_control | aurf_pkg::MASK_CTRL;
            aurf_pkg::ADDR_CH2_DUTY:  read_value = regs_reg.ch2_duty_length | aurf_pkg::MASK_DUTY;
            aurf_pkg::ADDR_CH2_ENV:   read_value = regs_reg.ch2_envelope;
            aurf_pkg::ADDR_CH2_CTRL:  read_value = regs_reg.ch2_control | aurf_pkg::MASK_CTRL;
            aurf_pkg::ADDR_CH3_EN:    read_value = regs_reg.ch3_enable | aurf_pkg::MASK_CH3EN;
            aurf_pkg::ADDR_CH3_LEVEL: read_value = regs_reg.ch3_level | aurf_pkg::MASK_LEVEL;
            aurf_pkg::ADDR_CH3_CTRL:  read_value = regs_reg.ch3_control | aurf_pkg::MASK_CTRL;
            aurf_pkg::ADDR_CH4_ENV:   read_value = regs_reg.ch4_envelope;
            aurf_pkg::ADDR_CH4_FREQ:  read_value = regs_reg.ch4_frequency;
            aurf_pkg::ADDR_CH4_CTRL:  read_value = regs_reg.ch4_control | aurf_pkg::MASK_CTRL;
            aurf_pkg::ADDR_VOLUME:    read_value = regs_reg.master_volume;
            aurf_pkg::ADDR_PANNING:   read_value = regs_reg.panning;
            aurf_pkg::ADDR_POWER:     read_value = (regs_reg.power_control & aurf_pkg::POWER_KEEP)
                                                   | aurf_pkg::MASK_POWER;
            default:                  read_value = wave_hit ? wave_reg[wave_idx]
                                                            : aurf_pkg::READ_NONE;
        endcase
    end

    always_comb
    begin
        regs_next = regs_reg;
        wave_we   = 1'b0;
        rd        = aurf_pkg::READ_NONE;
        phase     = regs_reg.tick_phase;
        len       = regs_reg.ch1_duty_length[5:0] + 6'd1;
        if (en)
        begin
            unique case (req.kind)
                aurf_pkg::KIND_READ:
                begin
                    rd = read_value;
                end
                aurf_pkg::KIND_WRITE:
                begin
                    unique case (req.address)
                        aurf_pkg::ADDR_SWEEP:     if (powered) regs_next.sweep_setting = d;
                        aurf_pkg::ADDR_CH1_DUTY:  regs_next.ch1_duty_length =
                                                      powered ? d : (d & aurf_pkg::MASK_DUTY);
                        aurf_pkg::ADDR_CH1_ENV:   if (powered) regs_next.ch1_envelope = d;
                        aurf_pkg::ADDR_CH1_PLOW:  if (powered) regs_next.ch1_period_low = d;
                        aurf_pkg::ADDR_CH1_CTRL:  if (powered) regs_next.ch1_control = d;
                        aurf_pkg::ADDR_CH2_DUTY:  regs_next.ch2_duty_length =
                                                      powered ? d : (d & aurf_pkg::MASK_DUTY);
                        aurf_pkg::ADDR_CH2_ENV:   if (powered) regs_next.ch2_envelope = d;
                        aurf_pkg::ADDR_CH2_PLOW:  if (powered) regs_next.ch2_period_low = d;
                        aurf_pkg::ADDR_CH2_CTRL:  if (powered) regs_next.ch2_control = d;
                        aurf_pkg::ADDR_CH3_EN:    if (powered) regs_next.ch3_enable = d;
                        aurf_pkg::ADDR_CH3_LEN:   regs_next.ch3_length = d;
                        aurf_pkg::ADDR_CH3_LEVEL: if (powered) regs_next.ch3_level = d;
                        aurf_pkg::ADDR_CH3_PLOW:  if (powered) regs_next.ch3_period_low = d;
                        aurf_pkg::ADDR_CH3_CTRL:  if (powered) regs_next.ch3_control = d;
                        aurf_pkg::ADDR_CH4_LEN:   regs_next.ch4_length = d;
                        aurf_pkg::ADDR_CH4_ENV:   if (powered) regs_next.ch4_envelope = d;
                        aurf_pkg::ADDR_CH4_FREQ:  if (powered) regs_next.ch4_frequency = d;
                        aurf_pkg::ADDR_CH4_CTRL:  if (powered) regs_next.ch4_control = d;
                        aurf_pkg::ADDR_VOLUME:    if (powered) regs_next.master_volume = d;
                        aurf_pkg::ADDR_PANNING:   if (powered) regs_next.panning = d;
                        aurf_pkg::ADDR_POWER:
                        begin
                            // power down clears all but lengths, tick phase and wave store
                            if (!d[7])
                            begin
                                regs_next = '0;
                                regs_next.ch1_duty_length =
                                    regs_reg.ch1_duty_length & aurf_pkg::MASK_DUTY;
                                regs_next.ch2_duty_length =
                                    regs_reg.ch2_duty_length & aurf_pkg::MASK_DUTY;
                                regs_next.ch3_length = regs_reg.ch3_length;
                                regs_next.ch4_length = regs_reg.ch4_length;
                                regs_next.tick_phase = regs_reg.tick_phase;
                            end
                            regs_next.power_control = d & aurf_pkg::POWER_KEEP;
                        end
                        default:                  wave_we = wave_hit;
                    endcase
                end
                aurf_pkg::KIND_TICK:
                begin
                    if (powered)
                    begin
                        phase = regs_reg.tick_phase + 4'd1;
                        if (!phase[0] && regs_reg.ch1_control[6])
                        begin
                            regs_next.ch1_duty_length =
                                {regs_reg.ch1_duty_length[7:6], len};
                            if (len == aurf_pkg::LEN_LAST)
                            begin
                                regs_next.power_control[0] = 1'b0;
                            end
                        end
                    end
                    if (phase == aurf_pkg::PHASE_WRAP)
                    begin
                        phase = '0;
                    end
                    regs_next.tick_phase = phase;
                end
                default:
                begin
                end
            endcase
        end
        rsp.read_data          = rd;
        rsp.channel_one_active = regs_next.power_control[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= REGS_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WAVE_BYTES; i++)
            begin
                wave_reg[i] <= '0;
            end
        end
        else if (wave_we)
        begin
            wave_reg[wave_idx] <= d;
        end
    end

endmodule
